// ===== src/mstk_pkg.sv =====
// shared constants and back-end state type for the kruskal spanning tree block
package mstk_pkg;

	localparam int VC_BITS    = 6;
	localparam int IDX_BITS   = 5;
	localparam int TOTAL_BITS = 21;
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [3:0] {
		B_IDLE,
		S_RD_I,
		S_LD_I,
		S_RD_J,
		S_CMP_J,
		S_WR_I,
		L_INIT,
		K_RD,
		K_EDGE,
		K_LU,
		K_LV,
		K_SW_RD,
		K_SW_CMP,
		E_RD,
		E_WR,
		E_SUM
	} mstk_state_t;

	typedef struct packed {
		logic push;
		logic full;
	} mstk_push_t;

endpackage

// ===== src/min_spanning_tree_kruskal.sv =====
// top level of the kruskal minimum spanning tree block
// The adjacency matrix streams in row-major, one weight per input beat, the
// final beat marked by last_entry; vertex_count is sampled on the first beat
// of each matrix (zero acts as one, above MAX_VERTICES clamps). The front end
// takes a beat every cycle while the queue has room and turns nonzero
// upper-triangle weights into edges; the back end writes them to the edge
// memory. After the final beat the back end runs an exchange sort over the E
// stored edges on one memory port, then kruskal selection with a label
// memory (with a relabel sweep over all N labels per tree edge), then emits
// N-1 tree-edge beats and one summary beat, or only the summary when the
// graph is not connected. Input beats of the next matrix are taken during
// that time until the queue fills. No clearing pass is needed after reset.
module min_spanning_tree_kruskal import mstk_pkg::*; #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [VC_BITS-1:0]     cfg_wdata,
	// matrix beats
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic                   last_entry,
	// result beats
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   result_kind,
	output logic [IDX_BITS-1:0]    edge_from,
	output logic [IDX_BITS-1:0]    edge_to,
	output logic [WEIGHT_BITS-1:0] edge_cost,
	output logic                   is_connected,
	output logic [TOTAL_BITS-1:0]  tree_total,
	output logic                   diagonal_zero,
	output logic                   last_result
);

	localparam int NB = $clog2(MAX_VERTICES + 1);
	localparam int VB = $clog2(MAX_VERTICES);
	localparam int RW = 3 + NB + 2 * VB + WEIGHT_BITS;

	mstk_push_t    push_ctl;
	logic [RW-1:0] push_data, head;
	logic          fifo_full, fifo_empty, pop;

	// scan and classify matrix entries
	mstk_front #(
		.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS),
		.NB(NB), .VB(VB), .RW(RW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.edge_weight(edge_weight), .last_entry(last_entry),
		.push_ctl(push_ctl), .fifo_full(fifo_full), .push_data(push_data)
	);

	// edge and end-of-matrix records in flight
	mstk_fifo #(.DW(RW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_ctl(push_ctl), .push_data(push_data), .full(fifo_full),
		.pop(pop), .empty(fifo_empty), .head(head)
	);

	// sort, select and emit
	mstk_back #(
		.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS),
		.NB(NB), .VB(VB), .RW(RW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.fifo_empty(fifo_empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .edge_from(edge_from), .edge_to(edge_to),
		.edge_cost(edge_cost), .is_connected(is_connected),
		.tree_total(tree_total), .diagonal_zero(diagonal_zero),
		.last_result(last_result)
	);

endmodule

// ===== src/mstk_front.sv =====
// front end: matrix scan, edge extraction and diagonal check
module mstk_front import mstk_pkg::*; #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16,
	parameter int NB = $clog2(MAX_VERTICES + 1),
	parameter int VB = $clog2(MAX_VERTICES),
	parameter int RW = 3 + NB + 2 * VB + WEIGHT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [VC_BITS-1:0]     cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic                   last_entry,
	output mstk_push_t             push_ctl,
	input  logic                   fifo_full,
	output logic [RW-1:0]          push_data
);

	logic [VC_BITS-1:0] vc_q;
	logic [NB-1:0]      n_q, r_q, c_q, n_use;
	logic               started_q, diag_q;
	logic               accept, in_range, is_edge, diag_new;

	always_comb begin
		if (started_q) begin
			n_use = n_q;
		end else if (vc_q == '0) begin
			n_use = NB'(1);
		end else if (int'(vc_q) > MAX_VERTICES) begin
			n_use = NB'(MAX_VERTICES);
		end else begin
			n_use = NB'(vc_q);
		end
	end

	assign accept   = in_valid && !fifo_full;
	assign in_stall = fifo_full;
	assign in_range = (r_q < n_use);
	assign is_edge  = in_range && (c_q > r_q) && (edge_weight != '0);
	assign diag_new = diag_q && !(in_range && (c_q == r_q) && (edge_weight != '0));

	assign push_ctl.push = accept && (is_edge || last_entry);
	assign push_ctl.full = fifo_full;
	assign push_data = {is_edge, last_entry, diag_new, n_use,
		VB'(r_q), VB'(c_q), edge_weight};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= VC_BITS'(1);
			started_q <= 1'b0;
			diag_q    <= 1'b1;
			r_q       <= '0;
			c_q       <= '0;
			n_q       <= NB'(1);
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			if (accept) begin
				if (last_entry) begin
					started_q <= 1'b0;
					diag_q    <= 1'b1;
					r_q       <= '0;
					c_q       <= '0;
				end else begin
					started_q <= 1'b1;
					n_q       <= n_use;
					diag_q    <= diag_new;
					if (in_range) begin
						if (c_q == n_use - NB'(1)) begin
							c_q <= '0;
							r_q <= r_q + NB'(1);
						end else begin
							c_q <= c_q + NB'(1);
						end
					end
				end
			end
		end
	end

endmodule

// ===== src/mstk_fifo.sv =====
// small queue between the front and back ends
module mstk_fifo import mstk_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mstk_push_t    push_ctl,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output logic [DW-1:0] head
);

	localparam int PB = $clog2(FIFO_DEPTH);

	logic [DW-1:0] mem_q [FIFO_DEPTH];
	logic [PB-1:0] wp_q, rp_q;
	logic [PB:0]   cnt_q;

	assign full  = (cnt_q == (PB+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ctl.push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ctl.push) begin
				wp_q <= wp_q + PB'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PB'(1);
			end
			cnt_q <= cnt_q + (PB+1)'(push_ctl.push) - (PB+1)'(pop);
		end
	end

endmodule

// ===== src/mstk_back.sv =====
// back end: edge store, exchange sort, kruskal selection and result output
module mstk_back import mstk_pkg::*; #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16,
	parameter int NB = $clog2(MAX_VERTICES + 1),
	parameter int VB = $clog2(MAX_VERTICES),
	parameter int RW = 3 + NB + 2 * VB + WEIGHT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fifo_empty,
	input  logic [RW-1:0]          head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   result_kind,
	output logic [IDX_BITS-1:0]    edge_from,
	output logic [IDX_BITS-1:0]    edge_to,
	output logic [WEIGHT_BITS-1:0] edge_cost,
	output logic                   is_connected,
	output logic [TOTAL_BITS-1:0]  tree_total,
	output logic                   diagonal_zero,
	output logic                   last_result
);

	localparam int ED = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
	localparam int CB = $clog2(ED + 1);
	localparam int AB = (ED > 1) ? $clog2(ED) : 1;
	localparam int EW = 2 * VB + WEIGHT_BITS;
	localparam int SW = (WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS;

	// queue record fields
	logic          r_edge, r_last, r_diag;
	logic [NB-1:0] r_n;
	logic [EW-1:0] r_e;
	assign {r_edge, r_last, r_diag, r_n, r_e} = head;

	logic [EW-1:0] emem [ED];
	logic [EW-1:0] tmem [MAX_VERTICES];
	logic [VB-1:0] lmem [MAX_VERTICES];

	logic [EW-1:0] e_rd_q, t_rd_q, held_q, edge_q;
	logic [VB-1:0] l_rd_q, lu_q, lv_q;

	logic [AB-1:0] e_raddr, e_waddr;
	logic [EW-1:0] e_wdata;
	logic          e_we, l_we, t_we;
	logic [VB-1:0] l_raddr, l_waddr, l_wdata;

	mstk_state_t   state_q, state_d;
	logic [CB-1:0] cnt_q, i_q, j_q, cur_q;
	logic [NB-1:0] n_q, nt_q, k_q;
	logic [VB-1:0] vj_q;
	logic          diag_q;
	logic [SW-1:0] sum_q;

	logic [CB-1:0] cnt_next;
	logic          out_free;
	logic          last_pop;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == B_IDLE) && !fifo_empty;
	assign last_pop = pop && r_last;
	assign cnt_next = cnt_q + CB'(r_edge);

	function automatic logic [WEIGHT_BITS-1:0] wt(input logic [EW-1:0] e);
		wt = e[WEIGHT_BITS-1:0];
	endfunction
	function automatic logic [VB-1:0] vu(input logic [EW-1:0] e);
		vu = e[EW-1 -: VB];
	endfunction
	function automatic logic [VB-1:0] vv(input logic [EW-1:0] e);
		vv = e[WEIGHT_BITS +: VB];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (last_pop) begin
					state_d = ((CB+1)'(cnt_next) >= (CB+1)'(2)) ? S_RD_I : L_INIT;
				end
			end
			S_RD_I:  state_d = S_LD_I;
			S_LD_I:  state_d = S_RD_J;
			S_RD_J:  state_d = S_CMP_J;
			S_CMP_J: state_d = (j_q + CB'(1) < cnt_q) ? S_RD_J : S_WR_I;
			S_WR_I: begin
				state_d = ((CB+1)'(i_q) + (CB+1)'(2) < (CB+1)'(cnt_q)) ? S_RD_I : L_INIT;
			end
			L_INIT: state_d = (NB'(vj_q) == n_q - NB'(1)) ? K_RD : L_INIT;
			K_RD: begin
				if (cur_q < cnt_q && nt_q < n_q) begin
					state_d = K_EDGE;
				end else if (nt_q == n_q - NB'(1)) begin
					state_d = E_RD;
				end else begin
					state_d = E_SUM;
				end
			end
			K_EDGE:   state_d = K_LU;
			K_LU:     state_d = K_LV;
			K_LV:     state_d = (lu_q != l_rd_q) ? K_SW_RD : K_RD;
			K_SW_RD:  state_d = K_SW_CMP;
			K_SW_CMP: state_d = (NB'(vj_q) == n_q - NB'(1)) ? K_RD : K_SW_RD;
			E_RD:     state_d = (k_q == nt_q) ? E_SUM : E_WR;
			E_WR:     state_d = out_free ? E_RD : E_WR;
			E_SUM:    state_d = out_free ? B_IDLE : E_SUM;
			default:  state_d = B_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		e_we    = 1'b0;
		e_waddr = cnt_q[AB-1:0];
		e_wdata = held_q;
		e_raddr = j_q[AB-1:0];
		l_we    = 1'b0;
		l_waddr = vj_q;
		l_wdata = lu_q;
		l_raddr = vj_q;
		t_we    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				e_we    = pop && r_edge;
				e_wdata = r_e;
			end
			S_RD_I:  e_raddr = i_q[AB-1:0];
			S_CMP_J: e_we = (e_rd_q[WEIGHT_BITS-1:0] < wt(held_q));
			S_WR_I: begin
				e_we    = 1'b1;
				e_waddr = i_q[AB-1:0];
			end
			L_INIT: begin
				l_we    = 1'b1;
				l_wdata = vj_q;
			end
			K_RD:     e_raddr = cur_q[AB-1:0];
			K_EDGE:   l_raddr = vu(e_rd_q);
			K_LU:     l_raddr = vv(edge_q);
			K_LV:     t_we = (lu_q != l_rd_q);
			K_SW_CMP: l_we = (l_rd_q == lv_q);
			default: ;
		endcase
		if (state_q == S_CMP_J) begin
			e_waddr = j_q[AB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			emem[e_waddr] <= e_wdata;
		end
		e_rd_q <= emem[e_raddr];
		if (l_we) begin
			lmem[l_waddr] <= l_wdata;
		end
		l_rd_q <= lmem[l_raddr];
		if (t_we) begin
			tmem[nt_q[VB-1:0]] <= edge_q;
		end
		t_rd_q <= tmem[k_q[VB-1:0]];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (last_pop) begin
					n_q    <= r_n;
					diag_q <= r_diag;
					i_q    <= '0;
					vj_q   <= '0;
				end
			end
			S_LD_I: begin
				held_q <= e_rd_q;
				j_q    <= i_q + CB'(1);
			end
			S_CMP_J: begin
				if (e_rd_q[WEIGHT_BITS-1:0] < wt(held_q)) begin
					held_q <= e_rd_q;
				end
				j_q <= j_q + CB'(1);
			end
			S_WR_I: i_q <= i_q + CB'(1);
			L_INIT: begin
				vj_q  <= vj_q + VB'(1);
				cur_q <= '0;
				nt_q  <= '0;
			end
			K_RD: begin
				k_q   <= '0;
				sum_q <= '0;
			end
			K_EDGE: edge_q <= e_rd_q;
			K_LU:   lu_q <= l_rd_q;
			K_LV: begin
				lv_q <= l_rd_q;
				vj_q <= '0;
				if (lu_q != l_rd_q) begin
					nt_q <= nt_q + NB'(1);
				end else begin
					cur_q <= cur_q + CB'(1);
				end
			end
			K_SW_CMP: begin
				vj_q <= vj_q + VB'(1);
				if (NB'(vj_q) == n_q - NB'(1)) begin
					cur_q <= cur_q + CB'(1);
				end
			end
			E_WR: begin
				if (out_free) begin
					k_q   <= k_q + NB'(1);
					sum_q <= sum_q + SW'(wt(t_rd_q));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_IDLE && pop) begin
				cnt_q <= cnt_next;
			end
			if (state_q == E_SUM && out_free) begin
				cnt_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == E_WR && out_free) begin
			out_valid <= 1'b1;
		end else if (state_q == E_SUM && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_WR && out_free) begin
			result_kind   <= 1'b0;
			edge_from     <= IDX_BITS'(vu(t_rd_q));
			edge_to       <= IDX_BITS'(vv(t_rd_q));
			edge_cost     <= wt(t_rd_q);
			is_connected  <= 1'b0;
			tree_total    <= '0;
			diagonal_zero <= 1'b0;
			last_result   <= 1'b0;
		end else if (state_q == E_SUM && out_free) begin
			result_kind   <= 1'b1;
			edge_from     <= '0;
			edge_to       <= '0;
			edge_cost     <= '0;
			is_connected  <= (nt_q == n_q - NB'(1));
			tree_total    <= (nt_q == n_q - NB'(1)) ? sum_q[TOTAL_BITS-1:0] : '0;
			diagonal_zero <= diag_q;
			last_result   <= 1'b1;
		end
	end

	a_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= ED)
		else $error("edge count beyond store depth");

	a_tree_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_RD) |-> (nt_q < n_q))
		else $error("tree larger than vertex count allows");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_SUM && out_free) |=> (state_q == B_IDLE && out_valid && last_result))
		else $error("summary beat not followed by idle");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the kruskal minimum spanning tree block: directed and random matrices against a built-in predictor
`default_nettype none

module tb_top;
	import mstk_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXV      = 32;
	localparam int WBITS     = 16;
	localparam int EDGE_CAP  = MAXV * (MAXV - 1) / 2;
	localparam int IDLE_MAX  = 10;
	localparam int DOG_LIMIT = 200000;
	localparam bit KIND_EDGE    = 1'b0;
	localparam bit KIND_SUMMARY = 1'b1;

	// one matrix entry as the driver sends it
	typedef struct {
		logic [WBITS-1:0] weight;
		logic             fin;
	} entry_t;

	// one result beat as the block should produce it
	typedef struct {
		logic                  kind;
		logic [IDX_BITS-1:0]   src;
		logic [IDX_BITS-1:0]   dst;
		logic [WBITS-1:0]      cost;
		logic                  conn;
		logic [TOTAL_BITS-1:0] total;
		logic                  dz;
		logic                  fin;
	} tree_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [VC_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [WBITS-1:0] edge_weight = '0;
	logic last_entry = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [IDX_BITS-1:0] edge_from;
	logic [IDX_BITS-1:0] edge_to;
	logic [WBITS-1:0] edge_cost;
	logic is_connected;
	logic [TOTAL_BITS-1:0] tree_total;
	logic diagonal_zero;
	logic last_result;

	min_spanning_tree_kruskal #(
		.MAX_VERTICES(MAXV),
		.WEIGHT_BITS (WBITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.edge_weight  (edge_weight),
		.last_entry   (last_entry),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.edge_cost    (edge_cost),
		.is_connected (is_connected),
		.tree_total   (tree_total),
		.diagonal_zero(diagonal_zero),
		.last_result  (last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	entry_t     matrix_q[$];   // entries waiting for the driver
	tree_beat_t tree_q[$];     // results still owed by the block
	int  errors = 0;
	int  matrices_sent = 0;
	int  matrices_taken = 0;
	bit  no_idle = 1'b0;       // when set both sides run without gaps
	int  in_gap = 0;
	int  out_gap = 0;
	int  quiet_cycles = 0;

	// ---------------------------------------------------------------
	// predictor state: a private copy of the block's run state
	// ---------------------------------------------------------------
	logic [VC_BITS-1:0] vc_reg = 6'd1;
	int unsigned        vc_latched = 1;
	int unsigned        scan_pos = 0;
	int unsigned        n_edges = 0;
	bit                 diag_clean = 1'b1;
	int unsigned        e_src[EDGE_CAP];
	int unsigned        e_dst[EDGE_CAP];
	logic [WBITS-1:0]   e_cost[EDGE_CAP];
	int unsigned        label[MAXV];

	function automatic int draw_idle();
		if (no_idle)
			return 0;
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// sort, select and push the expected beats for a finished matrix
	function automatic void build_tree();
		int unsigned      i, j, ts, td, taken, old_l, new_l, u, v;
		logic [WBITS-1:0] tc;
		logic [31:0]      sum;
		tree_beat_t       b;
		tree_beat_t       picked[$];
		// exchange sort: position i swaps with any later strictly lighter edge
		for (i = 0; i + 1 < n_edges; i++) begin
			for (j = i + 1; j < n_edges; j++) begin
				if (e_cost[i] > e_cost[j]) begin
					ts = e_src[i]; td = e_dst[i]; tc = e_cost[i];
					e_src[i] = e_src[j]; e_dst[i] = e_dst[j]; e_cost[i] = e_cost[j];
					e_src[j] = ts; e_dst[j] = td; e_cost[j] = tc;
				end
			end
		end
		for (i = 0; i < vc_latched; i++)
			label[i] = i;
		taken = 0;
		sum = 0;
		for (i = 0; i < n_edges && taken < vc_latched; i++) begin
			u = e_src[i];
			v = e_dst[i];
			if (u < vc_latched && v < vc_latched && label[u] != label[v]) begin
				b = '{KIND_EDGE, u[IDX_BITS-1:0], v[IDX_BITS-1:0], e_cost[i], 0, 0, 0, 0};
				picked.push_back(b);
				sum += e_cost[i];
				taken++;
				old_l = label[v];
				new_l = label[u];
				// merge the larger end's component into the smaller end's
				for (j = 0; j < vc_latched; j++)
					if (label[j] == old_l)
						label[j] = new_l;
			end
		end
		if (taken == vc_latched - 1) begin
			foreach (picked[k])
				tree_q.push_back(picked[k]);
			b = '{KIND_SUMMARY, 0, 0, 0, 1'b1, sum[TOTAL_BITS-1:0], diag_clean, 1'b1};
		end else begin
			b = '{KIND_SUMMARY, 0, 0, 0, 1'b0, '0, diag_clean, 1'b1};
		end
		tree_q.push_back(b);
		scan_pos = 0;
		n_edges = 0;
		diag_clean = 1'b1;
	endfunction

	// fold one accepted matrix entry into the predictor
	function void take_entry(logic [WBITS-1:0] w, logic fin);
		int unsigned r, c;
		if (scan_pos == 0)
			vc_latched = (vc_reg == 0) ? 1 : (vc_reg > MAXV) ? MAXV : vc_reg;
		// entries past n*n are dropped, but a final mark on one still counts
		if (scan_pos < vc_latched * vc_latched) begin
			r = scan_pos / vc_latched;
			c = scan_pos % vc_latched;
			if (r == c && w != 0)
				diag_clean = 1'b0;
			if (c > r && w != 0 && n_edges < EDGE_CAP) begin
				e_src[n_edges] = r;
				e_dst[n_edges] = c;
				e_cost[n_edges] = w;
				n_edges++;
			end
			scan_pos++;
		end
		if (fin)
			build_tree();
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------
	// driver: matrix beats from matrix_q, with random gaps
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		entry_t e;
		if (!arst_n) begin
			in_valid <= 1'b0;
			edge_weight <= '0;
			last_entry <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (matrix_q.size() > 0) begin
				e = matrix_q.pop_front();
				in_valid <= 1'b1;
				edge_weight <= e.weight;
				last_entry <= e.fin;
				in_gap <= draw_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall: a fresh wait drawn after every beat taken
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else if (out_valid && !out_stall) begin
			g = draw_idle();
			out_gap <= g;
			out_stall <= (g != 0);
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= (out_gap > 1);
		end
	end

	// ---------------------------------------------------------------
	// monitor: config writes, accepted entries and result beats
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		tree_beat_t x;
		if (arst_n) begin
			if (cfg_we)
				vc_reg <= cfg_wdata;
			if (in_valid && !in_stall) begin
				take_entry(edge_weight, last_entry);
				if (last_entry)
					matrices_taken++;
			end
			if (out_valid && !out_stall) begin
				if (tree_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none actual kind %0d",
						$time, result_kind);
					errors++;
				end else begin
					x = tree_q.pop_front();
					check_field("result_kind", x.kind, result_kind);
					check_field("edge_from", x.src, edge_from);
					check_field("edge_to", x.dst, edge_to);
					check_field("edge_cost", x.cost, edge_cost);
					check_field("is_connected", x.conn, is_connected);
					check_field("tree_total", x.total, tree_total);
					check_field("diagonal_zero", x.dz, diagonal_zero);
					check_field("last_result", x.fin, last_result);
				end
			end
		end
	end

	// watchdog: too long with no beat on either side ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= DOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	task automatic write_vc(int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[VC_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// queue one matrix and wait until every result of it has been checked
	task automatic send_matrix(logic [WBITS-1:0] w[$]);
		entry_t e;
		foreach (w[k]) begin
			e.weight = w[k];
			e.fin = (k == w.size() - 1);
			matrix_q.push_back(e);
		end
		matrices_sent++;
		do begin
			@(posedge clk);
			#1;
		end while (matrices_taken != matrices_sent || tree_q.size() != 0);
	endtask

	function automatic logic [WBITS-1:0] rand_weight(int style);
		case (style)
			0: return $urandom_range(1, 4);            // lots of ties
			1: return $urandom_range(1, 2 ** WBITS - 1);
			default: return ($urandom_range(0, 2) == 0) ? 16'd0 : $urandom_range(1, 50);
		endcase
	endfunction

	int sent_items = 0;

	initial begin
		logic [WBITS-1:0] m[$];
		logic [WBITS-1:0] sym[MAXV][MAXV];
		int n, style, cut;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single vertex at reset count, nonzero diagonal
		m = '{16'hFFFF};
		send_matrix(m);
		// zero count acts as one
		write_vc(0);
		m = '{16'h0000};
		send_matrix(m);
		// two vertices, heaviest weight
		write_vc(2);
		m = '{0, 16'hFFFF, 16'hFFFF, 0};
		send_matrix(m);
		// three vertices, disconnected (only one edge)
		write_vc(3);
		m = '{0, 5, 0, 5, 0, 0, 0, 0, 0};
		send_matrix(m);
		// surplus entries after n*n, final mark on a dropped one
		write_vc(2);
		m = '{0, 16'h8001, 16'h8001, 0, 16'h7FFE, 16'h1234};
		send_matrix(m);
		// largest count with an early final mark
		write_vc(MAXV);
		m = '{0, 9, 16'h00FF};
		send_matrix(m);
		// count above the maximum clamps
		write_vc(63);
		m = '{16'h0001, 16'h5555};
		send_matrix(m);
		sent_items = 26;

		// random matrices: mostly well-formed symmetric graphs
		while (sent_items < 270) begin
			n = ($urandom_range(0, 15) == 0) ? 8 : $urandom_range(2, 6);
			no_idle = ($urandom_range(0, 3) == 0);
			write_vc(n);
			style = $urandom_range(0, 2);
			for (int r = 0; r < n; r++)
				for (int c = r; c < n; c++) begin
					sym[r][c] = (r == c) ? 16'd0 : rand_weight(style);
					sym[c][r] = sym[r][c];
				end
			if ($urandom_range(0, 7) == 0)
				sym[0][0] = rand_weight(1);
			m.delete();
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++)
					m.push_back(($urandom_range(0, 9) == 0) ? rand_weight(1) : sym[r][c]);
			case ($urandom_range(0, 7))
				0: begin
					cut = $urandom_range(1, n * n - 1);
					while (m.size() > cut)
						void'(m.pop_back());
				end
				1: repeat ($urandom_range(1, 3)) m.push_back(rand_weight(1));
				default: ;
			endcase
			sent_items += m.size();
			send_matrix(m);
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && tree_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
